// ----- rtl/rqtf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rqtf_pkg;

  // Read length limit and field widths.
  localparam logic [15:0] MAX_READ_LENGTH   = 16'hFFFF;
  localparam int          LEN_W             = 16;
  localparam int          SCORE_W           = 9;
  localparam int          PENALTY_W         = 10;
  localparam int          SUM_W             = 26;
  localparam int          CFG_DATA_W        = 17;
  localparam int          CFG_INDEX_W       = 3;

  // Phred offsets and the low-quality score bound.
  localparam logic signed [SCORE_W-1:0] PHRED33_OFFSET    = 9'sd33;
  localparam logic signed [SCORE_W-1:0] PHRED64_OFFSET    = 9'sd64;
  localparam logic signed [SCORE_W-1:0] LOW_QUALITY_SCORE = 9'sd3;

  // Reset values of the configuration registers.
  localparam logic [16:0] LOW_QUALITY_LIMIT_RESET = 17'h1FFFF;
  localparam logic [15:0] MIN_KEPT_LENGTH_RESET   = 16'd40;

  // Nucleotide characters.
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHRED64_MODE      = 3'd0,
    REG_HARD_CLIP_LENGTH  = 3'd1,
    REG_TRIM_THRESHOLD    = 3'd2,
    REG_LOW_QUALITY_LIMIT = 3'd3,
    REG_MIN_KEPT_LENGTH   = 3'd4
  } reg_index_t;

  // Verdict codes.
  typedef enum logic [1:0] {
    VERDICT_PASS      = 2'd0,
    VERDICT_NON_ACGT  = 2'd1,
    VERDICT_LOW_QUAL  = 2'd2,
    VERDICT_TOO_SHORT = 2'd3
  } verdict_t;

  typedef struct packed {
    logic        phred64_mode;
    logic [15:0] hard_clip_length;
    logic [6:0]  trim_threshold;
    logic [16:0] low_quality_limit;
    logic [15:0] min_kept_length;
  } cfg_t;

  typedef struct packed {
    logic        read_pass;
    verdict_t    verdict;
    logic [15:0] kept_length;
    logic [15:0] low_quality_count;
    logic [15:0] original_length;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/rqtf_read_acc.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Per-read running state: counts, trim sums and the verdict at the last base.
module rqtf_read_acc
  import rqtf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        advance,
  input  wire logic [7:0]  base_char,
  input  wire logic [7:0]  quality_char,
  input  wire logic        last_base,
  output result_t          result
);

  logic [LEN_W-1:0]          base_position;
  logic                      non_acgt_seen;
  logic signed [SUM_W-1:0]   running_penalty_sum;
  logic signed [SUM_W-1:0]   min_penalty_sum;
  logic [LEN_W-1:0]          min_sum_position;
  logic [LEN_W-1:0]          low_quality_running;
  logic [LEN_W-1:0]          low_quality_at_min;
  logic signed [SCORE_W-1:0] last_counted_score;

  logic [LEN_W-1:0]          base_position_next;
  logic                      non_acgt_seen_next;
  logic signed [SUM_W-1:0]   running_penalty_sum_next;
  logic signed [SUM_W-1:0]   min_penalty_sum_next;
  logic [LEN_W-1:0]          min_sum_position_next;
  logic [LEN_W-1:0]          low_quality_running_next;
  logic [LEN_W-1:0]          low_quality_at_min_next;
  logic signed [SCORE_W-1:0] last_counted_score_next;

  logic [LEN_W-1:0]            clip_lim;
  logic                        is_acgt;
  logic signed [SCORE_W-1:0]   score;
  logic signed [PENALTY_W-1:0] penalty;
  logic signed [SUM_W-1:0]     sum_add;
  logic [LEN_W-1:0]            len;
  logic [LEN_W-1:0]            kept;
  logic [LEN_W-1:0]            lowq;
  logic signed [SCORE_W-1:0]   thr_s;
  verdict_t                    verdict_code;

  // Effective clip: zero means no hard clip.
  assign clip_lim = (cfg.hard_clip_length != '0) ? cfg.hard_clip_length : MAX_READ_LENGTH;

  assign is_acgt = (base_char == CHAR_A) || (base_char == CHAR_C) ||
                   (base_char == CHAR_G) || (base_char == CHAR_T);

  // Score and trim penalty for this base.
  assign score   = $signed({1'b0, quality_char}) -
                   (cfg.phred64_mode ? PHRED64_OFFSET : PHRED33_OFFSET);
  assign thr_s   = $signed({2'b00, cfg.trim_threshold});
  assign penalty = $signed({3'b000, cfg.trim_threshold}) -
                   $signed({score[SCORE_W-1], score});
  assign sum_add = running_penalty_sum +
                   $signed({{(SUM_W-PENALTY_W){penalty[PENALTY_W-1]}}, penalty});

  // State update for one base.
  always_comb begin
    base_position_next       = base_position;
    non_acgt_seen_next       = non_acgt_seen | ~is_acgt;
    running_penalty_sum_next = running_penalty_sum;
    min_penalty_sum_next     = min_penalty_sum;
    min_sum_position_next    = min_sum_position;
    low_quality_running_next = low_quality_running;
    low_quality_at_min_next  = low_quality_at_min;
    last_counted_score_next  = last_counted_score;
    if (base_position != MAX_READ_LENGTH) begin
      if (base_position < clip_lim) begin
        running_penalty_sum_next = sum_add;
        if (score <= LOW_QUALITY_SCORE) begin
          low_quality_running_next = low_quality_running + 16'd1;
        end
        if (sum_add <= min_penalty_sum) begin
          min_penalty_sum_next    = sum_add;
          min_sum_position_next   = base_position + 16'd1;
          low_quality_at_min_next = low_quality_running_next;
        end
        last_counted_score_next = score;
      end
      base_position_next = base_position + 16'd1;
    end
  end

  // Verdict from the state after this base.
  always_comb begin
    len  = (base_position_next < clip_lim) ? base_position_next : clip_lim;
    kept = len;
    lowq = low_quality_running_next;
    if ((cfg.trim_threshold != '0) && (len != '0) && (last_counted_score_next < thr_s)) begin
      kept = (min_sum_position_next < len) ? min_sum_position_next : len;
      lowq = low_quality_at_min_next;
    end
    if (non_acgt_seen_next) begin
      verdict_code = VERDICT_NON_ACGT;
    end else if (!cfg.low_quality_limit[16] && (lowq >= cfg.low_quality_limit[15:0])) begin
      verdict_code = VERDICT_LOW_QUAL;
    end else if (kept < cfg.min_kept_length) begin
      verdict_code = VERDICT_TOO_SHORT;
    end else begin
      verdict_code = VERDICT_PASS;
    end
    result.read_pass         = (verdict_code == VERDICT_PASS);
    result.verdict           = verdict_code;
    result.kept_length       = kept;
    result.low_quality_count = lowq;
    result.original_length   = base_position_next;
  end

  // State registers; cleared after each read's last base.
  always_ff @(posedge clk) begin
    if (rst || (advance && last_base)) begin
      base_position       <= '0;
      non_acgt_seen       <= 1'b0;
      running_penalty_sum <= '0;
      min_penalty_sum     <= '0;
      min_sum_position    <= '0;
      low_quality_running <= '0;
      low_quality_at_min  <= '0;
      last_counted_score  <= '0;
    end else if (advance) begin
      base_position       <= base_position_next;
      non_acgt_seen       <= non_acgt_seen_next;
      running_penalty_sum <= running_penalty_sum_next;
      min_penalty_sum     <= min_penalty_sum_next;
      min_sum_position    <= min_sum_position_next;
      low_quality_running <= low_quality_running_next;
      low_quality_at_min  <= low_quality_at_min_next;
      last_counted_score  <= last_counted_score_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/read_quality_trim_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Read quality trim and filter. Bases of a read stream in one per transfer, with
// last_base marking the final base; one verdict transfer leaves per read from the
// output register once the last base has left the input register. The block
// sustains one base per cycle: each base passes an input register and then the
// running-sum update (one 26-bit add and compare), with the verdict captured in
// an output register. Input is stalled only when a read's last base is waiting
// and the previous verdict is still held by a stalled output. Configuration
// should be written between reads, once all verdicts have been taken.
module read_quality_trim_filter
  import rqtf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Configuration write port
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // Base input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             base_char,
  input  wire logic [7:0]             quality_char,
  input  wire logic                   last_base,
  // Verdict output channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        read_pass,
  output logic [1:0]                  verdict,
  output logic [15:0]                 kept_length,
  output logic [15:0]                 low_quality_count,
  output logic [15:0]                 original_length
);

  cfg_t        cfg;
  logic        s1_valid;
  logic [7:0]  s1_base;
  logic [7:0]  s1_quality;
  logic        s1_last;
  logic        advance;
  logic        out_load;
  result_t     acc_result;
  result_t     out_result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phred64_mode      <= 1'b0;
      cfg.hard_clip_length  <= '0;
      cfg.trim_threshold    <= '0;
      cfg.low_quality_limit <= LOW_QUALITY_LIMIT_RESET;
      cfg.min_kept_length   <= MIN_KEPT_LENGTH_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_PHRED64_MODE:      cfg.phred64_mode      <= cfg_data[0];
        REG_HARD_CLIP_LENGTH:  cfg.hard_clip_length  <= cfg_data[15:0];
        REG_TRIM_THRESHOLD:    cfg.trim_threshold    <= cfg_data[6:0];
        REG_LOW_QUALITY_LIMIT: cfg.low_quality_limit <= cfg_data;
        REG_MIN_KEPT_LENGTH:   cfg.min_kept_length   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // The registered base moves on unless it ends a read and the held verdict is stalled.
  assign in_stall = s1_valid && s1_last && out_valid && out_stall;
  assign advance  = s1_valid && !in_stall;
  assign out_load = advance && s1_last;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_base    <= base_char;
      s1_quality <= quality_char;
      s1_last    <= last_base;
    end
  end

  rqtf_read_acc u_acc (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .advance      (advance),
    .base_char    (s1_base),
    .quality_char (s1_quality),
    .last_base    (s1_last),
    .result       (acc_result)
  );

  // Output register for the verdict transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result <= acc_result;
    end
  end

  assign read_pass         = out_result.read_pass;
  assign verdict           = out_result.verdict;
  assign kept_length       = out_result.kept_length;
  assign low_quality_count = out_result.low_quality_count;
  assign original_length   = out_result.original_length;

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rqtf_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYCLES   = 6;
  localparam int LONG_READ_BASES = 150;
  localparam int HOLD_CYCLES     = 120;
  localparam int PRESSURE_READS  = 40;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_BASES     = 70;

  localparam result_t NO_RESULT = '0;

  // One row of the directed part: either a register write or one base transfer.
  typedef struct {
    bit          is_write;
    reg_index_t  index;
    logic [16:0] value;
    logic [7:0]  base;
    logic [7:0]  qual;
    logic        last;
    bit          typed;
    result_t     want;
  } step_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             base_char = '0;
  logic [7:0]             quality_char = '0;
  logic                   last_base = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   read_pass;
  logic [1:0]             verdict;
  logic [15:0]            kept_length;
  logic [15:0]            low_quality_count;
  logic [15:0]            original_length;

  read_quality_trim_filter u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .base_char        (base_char),
    .quality_char     (quality_char),
    .last_base        (last_base),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .read_pass        (read_pass),
    .verdict          (verdict),
    .kept_length      (kept_length),
    .low_quality_count(low_quality_count),
    .original_length  (original_length)
  );

  always #10 clk = ~clk;

  // Shadow copy of the configuration registers.
  logic        phred64 = 1'b0;
  logic [15:0] clip_len = '0;
  logic [6:0]  trim_level = '0;
  logic [16:0] low_limit = LOW_QUALITY_LIMIT_RESET;
  logic [15:0] min_length = MIN_KEPT_LENGTH_RESET;

  // Per-read trim state of the predictor.
  int unsigned position = 0;
  bit          saw_non_acgt = 1'b0;
  int          penalty_sum = 0;
  int          penalty_min = 0;
  int unsigned min_position = 0;
  int unsigned low_run = 0;
  int unsigned low_at_min = 0;
  int          last_score = 0;

  result_t     pending_verdicts[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          bases_sent = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  int          hold_request = 0;

  // Directed part: extremes, every verdict, out-of-range scores, clip, trim and a
  // register change in the middle of a read.
  step_row_t directed_steps [32] = '{
    '{1'b0, REG_PHRED64_MODE, 17'd0, "A", "I", 1'b1, 1'b1,
      '{1'b0, VERDICT_TOO_SHORT, 16'd1, 16'd0, 16'd1}},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "N", "!", 1'b1, 1'b1,
      '{1'b0, VERDICT_NON_ACGT, 16'd1, 16'd1, 16'd1}},
    '{1'b0, REG_PHRED64_MODE, 17'd0, 8'h00, 8'hFF, 1'b1, 1'b1,
      '{1'b0, VERDICT_NON_ACGT, 16'd1, 16'd0, 16'd1}},
    '{1'b0, REG_PHRED64_MODE, 17'd0, 8'hFF, 8'h00, 1'b1, 1'b1,
      '{1'b0, VERDICT_NON_ACGT, 16'd1, 16'd1, 16'd1}},
    '{1'b1, REG_MIN_KEPT_LENGTH, 17'd0, 8'h00, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "G", "#", 1'b1, 1'b1,
      '{1'b1, VERDICT_PASS, 16'd1, 16'd1, 16'd1}},
    '{1'b1, REG_LOW_QUALITY_LIMIT, 17'd0, 8'h00, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "T", "I", 1'b1, 1'b1,
      '{1'b0, VERDICT_LOW_QUAL, 16'd1, 16'd0, 16'd1}},
    '{1'b1, REG_LOW_QUALITY_LIMIT, 17'd2, 8'h00, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "A", "!", 1'b0, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "C", 8'h22, 1'b1, 1'b1,
      '{1'b0, VERDICT_LOW_QUAL, 16'd2, 16'd2, 16'd2}},
    '{1'b1, REG_PHRED64_MODE, 17'd1, 8'h00, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "A", "@", 1'b0, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "C", "h", 1'b1, 1'b1,
      '{1'b1, VERDICT_PASS, 16'd2, 16'd1, 16'd2}},
    '{1'b1, REG_HARD_CLIP_LENGTH, 17'd2, 8'h00, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "A", "h", 1'b0, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "A", "h", 1'b0, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "N", "h", 1'b1, 1'b1,
      '{1'b0, VERDICT_NON_ACGT, 16'd2, 16'd0, 16'd3}},
    '{1'b1, REG_HARD_CLIP_LENGTH, 17'd0, 8'h00, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{1'b1, REG_TRIM_THRESHOLD, 17'd20, 8'h00, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "A", "h", 1'b0, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "C", "h", 1'b0, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "G", "J", 1'b0, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "T", "J", 1'b1, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "A", "@", 1'b1, 1'b0, NO_RESULT},
    '{1'b1, REG_TRIM_THRESHOLD, 17'd93, 8'h00, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{1'b1, REG_MIN_KEPT_LENGTH, 17'd65535, 8'h00, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{1'b1, REG_LOW_QUALITY_LIMIT, 17'h1FFFF, 8'h00, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "A", "h", 1'b1, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "A", "h", 1'b0, 1'b0, NO_RESULT},
    '{1'b1, REG_TRIM_THRESHOLD, 17'd0, 8'h00, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, REG_PHRED64_MODE, 17'd0, "C", "!", 1'b1, 1'b0, NO_RESULT}
  };

  // Advance the trim state by one base; returns 1 with the verdict on a last base.
  function automatic bit trim_filter_step(input logic [7:0] b, input logic [7:0] q,
                                          input logic last, output result_t res);
    int unsigned lim;
    int unsigned len;
    int unsigned kept;
    int unsigned lowq;
    int          score;
    verdict_t    code;
    res = '0;
    lim = (clip_len != 0 && clip_len < MAX_READ_LENGTH) ? clip_len : MAX_READ_LENGTH;
    if (b != CHAR_A && b != CHAR_C && b != CHAR_G && b != CHAR_T) saw_non_acgt = 1'b1;

    // Bases past the length limit or the clip are only checked for ACGT.
    if (position < MAX_READ_LENGTH) begin
      if (position < lim) begin
        score = int'(q) - (phred64 ? int'(PHRED64_OFFSET) : int'(PHRED33_OFFSET));
        penalty_sum += int'(trim_level) - score;
        if (score <= int'(LOW_QUALITY_SCORE)) low_run++;
        if (penalty_sum <= penalty_min) begin
          penalty_min = penalty_sum;
          min_position = position + 1;
          low_at_min = low_run;
        end
        last_score = score;
      end
      position++;
    end
    if (!last) return 1'b0;

    // The trim cuts back to the minimum of the running sum, but only when the
    // last counted base is below the threshold.
    len = position < lim ? position : lim;
    kept = len;
    lowq = low_run;
    if (trim_level > 0 && len > 0 && last_score < int'(trim_level)) begin
      kept = min_position < len ? min_position : len;
      lowq = low_at_min;
    end
    if (saw_non_acgt) code = VERDICT_NON_ACGT;
    else if (!low_limit[16] && lowq >= low_limit[15:0]) code = VERDICT_LOW_QUAL;
    else if (kept < min_length) code = VERDICT_TOO_SHORT;
    else code = VERDICT_PASS;
    res.read_pass = (code == VERDICT_PASS);
    res.verdict = code;
    res.kept_length = kept[15:0];
    res.low_quality_count = lowq[15:0];
    res.original_length = position[15:0];

    position = 0;
    saw_non_acgt = 1'b0;
    penalty_sum = 0;
    penalty_min = 0;
    min_position = 0;
    low_run = 0;
    low_at_min = 0;
    last_score = 0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] random_nucleotide();
    case ($urandom_range(0, 3))
      0: return CHAR_A;
      1: return CHAR_C;
      2: return CHAR_G;
      default: return CHAR_T;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [16:0] got,
                                 input logic [16:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Write one register; called at a rising edge while the block is idle.
  task automatic write_reg(input reg_index_t index, input logic [16:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (index)
      REG_PHRED64_MODE:      phred64 = value[0];
      REG_HARD_CLIP_LENGTH:  clip_len = value[15:0];
      REG_TRIM_THRESHOLD:    trim_level = value[6:0];
      REG_LOW_QUALITY_LIMIT: low_limit = value;
      REG_MIN_KEPT_LENGTH:   min_length = value[15:0];
      default: ;
    endcase
  endtask

  // Offer one base and wait for its transfer; the predictor runs on acceptance.
  task automatic send_base(input logic [7:0] b, input logic [7:0] q, input logic last,
                           input bit typed, input result_t typed_result);
    result_t predicted;
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    base_char <= b;
    quality_char <= q;
    last_base <= last;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    if (trim_filter_step(b, q, last, predicted))
      pending_verdicts.push_back(typed ? typed_result : predicted);
  endtask

  // Stop sending, let every verdict arrive, then let the pipeline settle.
  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A read with a good head and a weaker tail; noisy reads carry random bytes.
  task automatic send_read(input int unsigned length, input bit noisy);
    logic [7:0]  b;
    logic [7:0]  q;
    int unsigned offset;
    offset = phred64 ? 64 : 33;
    for (int unsigned i = 0; i < length; i++) begin
      b = random_nucleotide();
      if (i >= length * 3 / 4) q = 8'(offset + $urandom_range(0, 15));
      else q = 8'(offset + $urandom_range(0, 45));
      if (noisy && $urandom_range(0, 99) < 15) b = 8'($urandom_range(0, 255));
      if (noisy && $urandom_range(0, 99) < 15) q = 8'($urandom_range(0, 255));
      send_base(b, q, i == length - 1, 1'b0, NO_RESULT);
      bases_sent++;
    end
  endtask

  // Random settings for one phase, extremes included.
  task automatic pick_settings();
    logic [16:0] clip;
    logic [16:0] trim;
    logic [16:0] limit;
    logic [16:0] minimum;
    case ($urandom_range(0, 5))
      0, 1: clip = 17'd0;
      2: clip = 17'($urandom_range(1, 30));
      3: clip = 17'd65535;
      default: clip = 17'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 3))
      0: trim = 17'd0;
      1: trim = 17'd93;
      default: trim = 17'($urandom_range(1, 60));
    endcase
    case ($urandom_range(0, 4))
      0: limit = 17'h1FFFF;
      1: limit = 17'd0;
      2: limit = 17'd65535;
      default: limit = 17'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 5))
      0: minimum = 17'd0;
      1: minimum = 17'd65535;
      2: minimum = 17'd40;
      default: minimum = 17'($urandom_range(1, 30));
    endcase
    wait_for_verdicts();
    write_reg(REG_PHRED64_MODE, 17'($urandom_range(0, 1)));
    write_reg(REG_HARD_CLIP_LENGTH, clip);
    write_reg(REG_TRIM_THRESHOLD, trim);
    write_reg(REG_LOW_QUALITY_LIMIT, limit);
    write_reg(REG_MIN_KEPT_LENGTH, minimum);
  endtask

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    int hold_left;
    int burst_left;
    hold_left = 0;
    burst_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst_left = $urandom_range(1, 8) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check each verdict transfer mid-cycle and watch for a stuck handshake.
  always @(negedge clk) begin
    result_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("verdict with none pending", 17'(verdict), 17'd0);
        end else begin
          want = pending_verdicts.pop_front();
          if (read_pass !== want.read_pass)
            report_mismatch("read_pass", 17'(read_pass), 17'(want.read_pass));
          if (verdict !== want.verdict)
            report_mismatch("verdict", 17'(verdict), 17'(want.verdict));
          if (kept_length !== want.kept_length)
            report_mismatch("kept_length", 17'(kept_length), 17'(want.kept_length));
          if (low_quality_count !== want.low_quality_count)
            report_mismatch("low_quality_count", 17'(low_quality_count),
                            17'(want.low_quality_count));
          if (original_length !== want.original_length)
            report_mismatch("original_length", 17'(original_length),
                            17'(want.original_length));
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", quiet_cycles);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed rows.
    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_write) begin
        wait_for_verdicts();
        write_reg(directed_steps[i].index, directed_steps[i].value);
      end else begin
        send_base(directed_steps[i].base, directed_steps[i].qual, directed_steps[i].last,
                  directed_steps[i].typed, directed_steps[i].want);
      end
    end

    // One long read with the clip at its maximum.
    wait_for_verdicts();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_reg(REG_PHRED64_MODE, 17'd0);
    write_reg(REG_HARD_CLIP_LENGTH, 17'd65535);
    write_reg(REG_TRIM_THRESHOLD, 17'($urandom_range(0, 93)));
    write_reg(REG_LOW_QUALITY_LIMIT, 17'd65535);
    write_reg(REG_MIN_KEPT_LENGTH, 17'd40);
    send_read(LONG_READ_BASES, 1'b0);

    // Back-pressure: the receiver holds off while short reads keep coming.
    wait_for_verdicts();
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < PRESSURE_READS; i++)
      send_base(random_nucleotide(), "I", 1'b1, 1'b0, NO_RESULT);
    wait_for_verdicts();

    // Random phases; the last one runs without idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      tx_gaps = (p != RANDOM_PHASES - 1);
      rx_gaps = (p != RANDOM_PHASES - 1);
      pick_settings();
      bases_sent = 0;
      while (bases_sent < PHASE_BASES) begin
        case ($urandom_range(0, 9))
          0: send_read(1, $urandom_range(0, 7) == 0);
          1: send_read($urandom_range(60, 120), $urandom_range(0, 7) == 0);
          default: send_read($urandom_range(2, 50), $urandom_range(0, 7) == 0);
        endcase
      end
    end

    wait_for_verdicts();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
